[hw/rtl/matrix_inverse_3x3_macros.svh]
// Assertion macros for the 3x3 matrix inverse.
`ifndef MATRIX_INVERSE_3X3_MACROS_SVH
`define MATRIX_INVERSE_3X3_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define MI3_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked during reset too.
`define MI3_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/mi3_pkg.sv]
// Package for the 3x3 matrix inverse: default widths and cofactor index tables.
`timescale 1ns / 1ps
package mi3_pkg;

  localparam int WIDTH_DEF     = 32;
  localparam int FRAC_BITS_DEF = 16;

  // cof[i] = m[A]*m[B] - m[C]*m[D]
  localparam int unsigned COF_A [9] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam int unsigned COF_B [9] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
  localparam int unsigned COF_C [9] = '{7, 1, 2, 3, 2, 0, 6, 0, 1};
  localparam int unsigned COF_D [9] = '{5, 8, 4, 8, 6, 5, 4, 7, 3};

  // det = m0*cof0 + m1*cof3 + m2*cof6
  localparam int unsigned DET_COF [3] = '{0, 3, 6};

endpackage

[hw/rtl/matrix_inverse_3x3.sv]
// 3x3 fixed-point matrix inverse by adjugate, fully pipelined.
// Throughput: one matrix per cycle; the pipeline holds as a whole while out_valid waits.
// The depth is set by the restoring divider, one quotient bit per stage, WIDTH+1 stages.
// Reset (rst_n low, synchronous) clears all stage valid bits; data registers are not reset.
`timescale 1ns / 1ps
`include "matrix_inverse_3x3_macros.svh"

module matrix_inverse_3x3 import mi3_pkg::*; #(
  parameter int WIDTH     = WIDTH_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [WIDTH-1:0] in_m00,
  input  logic signed [WIDTH-1:0] in_m01,
  input  logic signed [WIDTH-1:0] in_m02,
  input  logic signed [WIDTH-1:0] in_m10,
  input  logic signed [WIDTH-1:0] in_m11,
  input  logic signed [WIDTH-1:0] in_m12,
  input  logic signed [WIDTH-1:0] in_m20,
  input  logic signed [WIDTH-1:0] in_m21,
  input  logic signed [WIDTH-1:0] in_m22,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [WIDTH-1:0] out_inv00,
  output logic signed [WIDTH-1:0] out_inv01,
  output logic signed [WIDTH-1:0] out_inv02,
  output logic signed [WIDTH-1:0] out_inv10,
  output logic signed [WIDTH-1:0] out_inv11,
  output logic signed [WIDTH-1:0] out_inv12,
  output logic signed [WIDTH-1:0] out_inv20,
  output logic signed [WIDTH-1:0] out_inv21,
  output logic signed [WIDTH-1:0] out_inv22,
  output logic                    out_singular,
  output logic                    out_overflow
);

  localparam int W    = WIDTH;
  localparam int PW   = 2 * W;         // entry product
  localparam int CW   = 2 * W + 1;     // cofactor
  localparam int HW   = 2 * W + 1;     // det partial product
  localparam int TW   = 3 * W + 2;     // det term
  localparam int DW   = 3 * W + 4;     // determinant
  localparam int NA   = CW + 2 * FRAC_BITS + 1;
  localparam int NW   = ((NA > DW) ? NA : DW) + 1;
  localparam int SA   = DW + W + 2;
  localparam int XW   = ((NW > SA) ? NW : SA) + 1;
  localparam int NS   = W + 8;         // register stages

  logic en;
  logic [NS-1:0] vld_r;

  assign en        = !vld_r[NS-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld_r[NS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NS-2:0], in_valid};
    end
  end

  logic signed [W-1:0] m [9];
  assign m[0] = in_m00;
  assign m[1] = in_m01;
  assign m[2] = in_m02;
  assign m[3] = in_m10;
  assign m[4] = in_m11;
  assign m[5] = in_m12;
  assign m[6] = in_m20;
  assign m[7] = in_m21;
  assign m[8] = in_m22;

  // stage 0: entry products
  logic signed [PW-1:0] pa_r [9];
  logic signed [PW-1:0] pb_r [9];
  logic signed [W-1:0]  m0_r [3];
  // stage 1: cofactors
  logic signed [CW-1:0] cof1_r [9];
  logic signed [W-1:0]  m1_r [3];
  // stage 2: det partial products
  logic signed [HW-1:0] hi_r [3];
  logic signed [HW-1:0] lo_r [3];
  logic signed [CW-1:0] cof2_r [9];
  // stage 3: det terms
  logic signed [TW-1:0] t_r [3];
  logic signed [CW-1:0] cof3_r [9];
  // stage 4: determinant
  logic signed [DW-1:0] det_r;
  logic signed [CW-1:0] cof4_r [9];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 9; i++) begin
        pa_r[i]   <= m[COF_A[i]] * m[COF_B[i]];
        pb_r[i]   <= m[COF_C[i]] * m[COF_D[i]];
        cof1_r[i] <= CW'(pa_r[i]) - CW'(pb_r[i]);
        cof2_r[i] <= cof1_r[i];
        cof3_r[i] <= cof2_r[i];
        cof4_r[i] <= cof3_r[i];
      end
      for (int j = 0; j < 3; j++) begin
        m0_r[j] <= m[j];
        m1_r[j] <= m0_r[j];
        hi_r[j] <= HW'(m1_r[j]) * HW'($signed(cof1_r[DET_COF[j]][CW-1:W]));
        lo_r[j] <= HW'(m1_r[j]) * HW'($signed({1'b0, cof1_r[DET_COF[j]][W-1:0]}));
        t_r[j]  <= (TW'(hi_r[j]) <<< W) + TW'(lo_r[j]);
      end
      det_r <= DW'(t_r[0]) + DW'(t_r[1]) + DW'(t_r[2]);
    end
  end

  // stage 5: magnitudes, rounding offset, overflow precheck
  logic [DW-1:0] dmag;
  logic [XW-1:0] den_nxt;
  logic [CW-1:0] cmag [9];
  logic [XW-1:0] num_nxt [9];
  logic          neg_nxt [9];
  logic          povf_nxt [9];

  logic [XW-1:0] rem5_r [9];
  logic [XW-1:0] den5_r;
  logic          neg5_r [9];
  logic          povf5_r [9];
  logic          sing5_r;

  always_comb begin
    dmag    = det_r[DW-1] ? DW'(-det_r) : DW'(det_r);
    den_nxt = XW'(dmag) << 1;
    for (int i = 0; i < 9; i++) begin
      cmag[i]     = cof4_r[i][CW-1] ? CW'(-cof4_r[i]) : CW'(cof4_r[i]);
      num_nxt[i]  = (XW'(cmag[i]) << (2 * FRAC_BITS + 1)) + XW'(dmag);
      neg_nxt[i]  = (cof4_r[i][CW-1] ^ det_r[DW-1]) && (cof4_r[i] != '0);
      povf_nxt[i] = num_nxt[i] >= (den_nxt << (W + 1));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem5_r  <= num_nxt;
      den5_r  <= den_nxt;
      neg5_r  <= neg_nxt;
      povf5_r <= povf_nxt;
      sing5_r <= (det_r == '0);
    end
  end

  // restoring divider, one quotient bit per stage, MSB first
  logic [XW-1:0] drem_r  [W][9];
  logic [W:0]    dq_r    [W+1][9];
  logic [XW-1:0] dden_r  [W+1];
  logic          dneg_r  [W+1][9];
  logic          dovf_r  [W+1][9];
  logic          dsing_r [W+1];

  for (genvar j = 0; j <= W; j++) begin : g_div
    localparam int B = W - j;
    logic [XW-1:0] rem_i [9];
    logic [W:0]    q_i [9];
    logic [XW-1:0] den_i;
    logic          neg_i [9];
    logic          ovf_i [9];
    logic          sing_i;
    logic [XW-1:0] sh;
    logic [XW-1:0] rem_nxt [9];
    logic [W:0]    q_nxt [9];

    if (j == 0) begin : g_first
      assign rem_i  = rem5_r;
      assign q_i    = '{default: '0};
      assign den_i  = den5_r;
      assign neg_i  = neg5_r;
      assign ovf_i  = povf5_r;
      assign sing_i = sing5_r;
    end else begin : g_next
      assign rem_i  = drem_r[j-1];
      assign q_i    = dq_r[j-1];
      assign den_i  = dden_r[j-1];
      assign neg_i  = dneg_r[j-1];
      assign ovf_i  = dovf_r[j-1];
      assign sing_i = dsing_r[j-1];
    end

    assign sh = den_i << B;

    always_comb begin
      for (int i = 0; i < 9; i++) begin
        if (rem_i[i] >= sh) begin
          rem_nxt[i] = rem_i[i] - sh;
          q_nxt[i]   = q_i[i] | ((W + 1)'(1) << B);
        end else begin
          rem_nxt[i] = rem_i[i];
          q_nxt[i]   = q_i[i];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dq_r[j]    <= q_nxt;
        dden_r[j]  <= den_i;
        dneg_r[j]  <= neg_i;
        dovf_r[j]  <= ovf_i;
        dsing_r[j] <= sing_i;
      end
    end

    if (j < W) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          drem_r[j] <= rem_nxt;
        end
      end
    end else begin : g_last
      // remainder of the last bit is not needed
      logic unused_rem;
      assign unused_rem = ^{rem_nxt[0], rem_nxt[1], rem_nxt[2], rem_nxt[3], rem_nxt[4],
                            rem_nxt[5], rem_nxt[6], rem_nxt[7], rem_nxt[8]};
    end
  end

  // output stage: saturate and sign, zero the result when singular
  localparam logic [W:0] HALF = (W + 1)'(1) << (W - 1);

  logic [W:0]          lim [9];
  logic                sat [9];
  logic [W:0]          mag [9];
  logic [W:0]          sval [9];
  logic signed [W-1:0] inv_nxt [9];
  logic                ovf_nxt;

  logic signed [W-1:0] inv_r [9];
  logic                sing_r;
  logic                ovf_r;

  always_comb begin
    ovf_nxt = 1'b0;
    for (int i = 0; i < 9; i++) begin
      lim[i]  = dneg_r[W][i] ? HALF : HALF - (W + 1)'(1);
      sat[i]  = dovf_r[W][i] || (dq_r[W][i] > lim[i]);
      mag[i]  = sat[i] ? lim[i] : dq_r[W][i];
      sval[i] = dneg_r[W][i] ? (W + 1)'(-mag[i]) : mag[i];
      if (dsing_r[W]) begin
        inv_nxt[i] = '0;
      end else begin
        inv_nxt[i] = $signed(sval[i][W-1:0]);
        ovf_nxt    = ovf_nxt | sat[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      inv_r  <= inv_nxt;
      sing_r <= dsing_r[W];
      ovf_r  <= ovf_nxt;
    end
  end

  assign out_inv00    = inv_r[0];
  assign out_inv01    = inv_r[1];
  assign out_inv02    = inv_r[2];
  assign out_inv10    = inv_r[3];
  assign out_inv11    = inv_r[4];
  assign out_inv12    = inv_r[5];
  assign out_inv20    = inv_r[6];
  assign out_inv21    = inv_r[7];
  assign out_inv22    = inv_r[8];
  assign out_singular = sing_r;
  assign out_overflow = ovf_r;

  `MI3_ASSERT_NEXT(a_rst_flush, !rst_n, vld_r == '0, "reset left a stage valid")
  `MI3_ASSERT_IMP(a_sing_zero, out_valid && out_singular,
                  !out_overflow && out_inv00 == '0 && out_inv22 == '0,
                  "singular transaction with nonzero result")
  `MI3_ASSERT_IMP(a_empty_ready, !out_valid, in_ready, "pipeline stalled with empty output")

endmodule

[sim/matrix_inverse_3x3_tb.sv]
// Testbench for the 3x3 fixed-point matrix inverse: random and directed matrices, scoreboard check.
`timescale 1ns / 1ps

class inverse_scoreboard;
  typedef struct {
    logic [31:0] inv [9];
    logic        singular;
    logic        overflow;
  } inverse_t;

  inverse_t pending_inverses[$];
  int       mismatches;

  function void note_matrix(logic signed [31:0] m [9]);
    logic signed [127:0] cof [9];
    logic signed [127:0] det;
    logic [255:0]        num, den, q;
    logic [63:0]         lim;
    logic                neg;
    inverse_t            e;
    cof[0] = m[4] * m[8] - m[7] * m[5];
    cof[1] = m[2] * m[7] - m[1] * m[8];
    cof[2] = m[1] * m[5] - m[2] * m[4];
    cof[3] = m[5] * m[6] - m[3] * m[8];
    cof[4] = m[0] * m[8] - m[2] * m[6];
    cof[5] = m[2] * m[3] - m[0] * m[5];
    cof[6] = m[3] * m[7] - m[6] * m[4];
    cof[7] = m[1] * m[6] - m[0] * m[7];
    cof[8] = m[0] * m[4] - m[1] * m[3];
    det = m[0] * cof[0] + m[1] * cof[3] + m[2] * cof[6];
    e.singular = (det == 0);
    e.overflow = 1'b0;
    for (int i = 0; i < 9; i++) begin
      e.inv[i] = '0;
      if (!e.singular) begin
        neg = (cof[i] < 0) != (det < 0);
        if (cof[i] == 0) neg = 1'b0;
        num = cof[i] < 0 ? 256'(-cof[i]) : 256'(cof[i]);
        den = det < 0 ? 256'(-det) : 256'(det);
        num = (num << 33) + den;
        q = num / (den << 1);
        lim = neg ? 64'h8000_0000 : 64'h7fff_ffff;
        if (q > 256'(lim)) begin
          e.overflow = 1'b1;
          q = 256'(lim);
        end
        e.inv[i] = neg ? 32'(-q[31:0]) : q[31:0];
      end
    end
    pending_inverses.push_back(e);
  endfunction

  function void check_inverse(logic [31:0] got [9], logic sing, logic ovf);
    inverse_t e;
    logic     bad;
    if (pending_inverses.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result transaction");
      return;
    end
    e = pending_inverses.pop_front();
    bad = (sing !== e.singular) || (ovf !== e.overflow);
    for (int i = 0; i < 9; i++) if (got[i] !== e.inv[i]) bad = 1'b1;
    if (bad) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch: exp sing=%0b ovf=%0b got sing=%0b ovf=%0b",
                 e.singular, e.overflow, sing, ovf);
        for (int i = 0; i < 9; i++)
          $display("  inv[%0d] exp %h got %h", i, e.inv[i], got[i]);
      end
    end
  endfunction
endclass

module matrix_inverse_3x3_tb;
  localparam int STALL_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] in_m [9];
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_inv [9];
  logic out_singular, out_overflow;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int idle_cycles = 0;
  inverse_scoreboard sb = new();

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial for (int i = 0; i < 9; i++) in_m[i] = '0;

  matrix_inverse_3x3 dut (
    .clk, .rst_n, .in_valid, .in_ready,
    .in_m00(in_m[0]), .in_m01(in_m[1]), .in_m02(in_m[2]),
    .in_m10(in_m[3]), .in_m11(in_m[4]), .in_m12(in_m[5]),
    .in_m20(in_m[6]), .in_m21(in_m[7]), .in_m22(in_m[8]),
    .out_valid, .out_ready,
    .out_inv00(out_inv[0]), .out_inv01(out_inv[1]), .out_inv02(out_inv[2]),
    .out_inv10(out_inv[3]), .out_inv11(out_inv[4]), .out_inv12(out_inv[5]),
    .out_inv20(out_inv[6]), .out_inv21(out_inv[7]), .out_inv22(out_inv[8]),
    .out_singular, .out_overflow
  );

  always @(posedge clk) begin
    logic [31:0] got [9];
    if (rst_n) begin
      if (out_valid && out_ready) begin
        for (int i = 0; i < 9; i++) got[i] = out_inv[i];
        sb.check_inverse(got, out_singular, out_overflow);
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_matrix(input logic signed [31:0] m [9]);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    for (int i = 0; i < 9; i++) in_m[i] <= m[i];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_matrix(m);
  endtask

  function automatic logic [31:0] rand_entry(int kind);
    case (kind)
      0: return $urandom();
      1: return $urandom_range(0, 32'h0003_ffff) - 32'h0002_0000;
      2: return $urandom_range(0, 32'h00ff_ffff) - 32'h0080_0000;
      default: return $urandom_range(0, 8) - 4;
    endcase
  endfunction

  initial begin
    logic signed [31:0] m [9];
    int kind;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // identity, zero, extremes, singular, scaled identity, tiny determinant, then random matrices
    for (int t = 0; t < 20; t++) begin
      for (int i = 0; i < 9; i++) begin
        case (t)
          0: m[i] = (i % 4 == 0) ? 32'h0001_0000 : 0;
          1: m[i] = 0;
          2: m[i] = 32'h7fff_ffff;
          3: m[i] = 32'h8000_0000;
          4: m[i] = (i % 4 == 0) ? 32'h8000_0000 : 0;
          5: m[i] = (i % 4 == 0) ? 32'h7fff_ffff : 0;
          6: m[i] = (i % 4 == 0) ? 32'sd1 : 0;
          7: m[i] = (i % 4 == 0) ? -32'sd1 : 0;
          8: m[i] = (i % 4 == 0) ? 32'h8000_0000 : 32'h7fff_ffff;
          9: m[i] = 32'hffff_ffff;
          10: m[i] = (i < 3) ? 32'h0001_0000 : (i < 6 ? 32'h0002_0000 : 32'h0003_0000);
          11: m[i] = (i % 4 == 0) ? 32'h0100_0000 : 0;
          12: m[i] = (i % 4 == 0) ? -32'sh0002_0000 : 0;
          default: m[i] = rand_entry(t % 4);
        endcase
      end
      send_matrix(m);
    end
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
        3: begin send_idle_pct = 9;  recv_stall_pct = 9;  end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      for (int n = 0; n < 390; n++) begin
        kind = $urandom_range(3);
        for (int i = 0; i < 9; i++) m[i] = rand_entry(kind);
        if ($urandom_range(9) == 0) for (int i = 0; i < 3; i++) m[6 + i] = m[3 + i];
        send_matrix(m);
      end
    end
    in_valid <= 1'b0;
    recv_stall_pct = 0;
    while (sb.pending_inverses.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_inverses.size() == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule

[matrix_inverse_3x3.f]
+incdir+hw/rtl
hw/rtl/mi3_pkg.sv
hw/rtl/matrix_inverse_3x3.sv
sim/matrix_inverse_3x3_tb.sv
